// File: rtl/checked_frame_deframer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checked frame deframer
// Concurrent checks sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHECKED_FRAME_DEFRAMER_ASSERT_SVH
`define CHECKED_FRAME_DEFRAMER_ASSERT_SVH

// Same-cycle implication.
`define CFD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cfd assertion failed");

// Next-cycle implication.
`define CFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cfd assertion failed");

`endif

// File: rtl/cfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Types, constants and the CRC-32C byte update shared by the deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

	localparam int HEADER_LEN     = 28;
	localparam int CRC_COVER      = 24;
	localparam int PAYLOAD_CRC_AT = 20;
	localparam int COUNT_W        = 33;
	localparam int HDR_IDX_W      = $clog2(HEADER_LEN);
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_DATA_W     = 64;
	localparam int TYPE_BITS      = 6;

	localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [31:0] MAGIC_RST   = 32'h0000_0000;
	localparam logic [15:0] VERSION_RST = 16'h0000;
	localparam logic [31:0] LIMIT_RST   = 32'hFFFF_FFFF;
	localparam logic [63:0] MASK_RST    = 64'h0000_0000_1FFF_FFFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_MAGIC      = 8'd0,
		CFG_ACCEPTED_VERSION = 8'd1,
		CFG_PAYLOAD_LIMIT    = 8'd2,
		CFG_KNOWN_TYPE_MASK  = 8'd3
	} cfd_cfg_idx_t;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_SHORT       = 4'd1,
		ST_MAGIC       = 4'd2,
		ST_HEADER_CRC  = 4'd3,
		ST_VERSION     = 4'd4,
		ST_TYPE        = 4'd5,
		ST_TOO_BIG     = 4'd6,
		ST_LENGTH      = 4'd7,
		ST_PAYLOAD_CRC = 4'd8
	} cfd_status_t;

	typedef struct packed {
		logic [31:0] frame_magic;
		logic [15:0] accepted_version;
		logic [31:0] payload_limit;
		logic [63:0] known_type_mask;
	} cfd_cfg_t;

	// Frame state as it stands after the current byte.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [31:0]        magic;
		logic [15:0]        version;
		logic [15:0]        message_type;
		logic [31:0]        payload_length;
		logic [63:0]        request_tag;
		logic [31:0]        payload_crc_field;
		logic [31:0]        header_crc_field;
		logic [31:0]        header_crc_calc;
		logic [31:0]        payload_crc_calc;
	} cfd_view_t;

	typedef struct packed {
		cfd_status_t status;
		logic [15:0] message_type;
		logic [63:0] request_tag;
		logic [31:0] payload_length;
	} cfd_result_t;

	// Reflected CRC-32C, one byte.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] d);
		logic [31:0] c;
		c = crc ^ {24'd0, d};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: rtl/cfd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_if
// Valid/ready channels of the deframer: byte input, verdict output, config.
// ----------------------------------------------------------------------------
interface cfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface cfd_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [15:0] message_type;
	logic [63:0] request_tag;
	logic [31:0] payload_length;

	modport source (output valid, output status, output message_type,
		output request_tag, output payload_length, input ready);
	modport sink (input valid, input status, input message_type,
		input request_tag, input payload_length, output ready);
endinterface

interface cfd_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cfd_pkg::CFG_IDX_W-1:0]  index;
	logic [cfd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/cfd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module cfd_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	cfd_cfg_if.sink           cfg,
	output cfd_pkg::cfd_cfg_t regs
);

	cfd_pkg::cfd_cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.frame_magic      <= cfd_pkg::MAGIC_RST;
			regs_q.accepted_version <= cfd_pkg::VERSION_RST;
			regs_q.payload_limit    <= cfd_pkg::LIMIT_RST;
			regs_q.known_type_mask  <= cfd_pkg::MASK_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				cfd_pkg::CFG_FRAME_MAGIC: begin
					regs_q.frame_magic <= cfg.data[31:0];
				end
				cfd_pkg::CFG_ACCEPTED_VERSION: begin
					regs_q.accepted_version <= cfg.data[15:0];
				end
				cfd_pkg::CFG_PAYLOAD_LIMIT: begin
					regs_q.payload_limit <= cfg.data[31:0];
				end
				cfd_pkg::CFG_KNOWN_TYPE_MASK: begin
					regs_q.known_type_mask <= cfg.data;
				end
				default: begin
					// unmapped index: drop the write
				end
			endcase
		end
	end

endmodule

// File: rtl/cfd_frame_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_frame_state
// Byte counter, header store and both running CRCs of the current frame.
// ----------------------------------------------------------------------------
module cfd_frame_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         data_b,
	input  logic               last,
	output cfd_pkg::cfd_view_t view
);

	localparam int CW = cfd_pkg::COUNT_W;
	localparam int IW = cfd_pkg::HDR_IDX_W;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_n;
	logic [31:0]   hcrc_q;
	logic [31:0]   hcrc_n;
	logic [31:0]   pcrc_q;
	logic [31:0]   pcrc_n;
	logic [7:0]    hdr_q [cfd_pkg::HEADER_LEN];
	logic [7:0]    hdr_v [cfd_pkg::HEADER_LEN];
	logic          hdr_wr;
	logic [IW-1:0] hdr_idx;

	assign hdr_wr  = cnt_q < CW'(cfd_pkg::HEADER_LEN);
	assign hdr_idx = cnt_q[IW-1:0];

	always_comb begin
		cnt_n  = (cnt_q == {CW{1'b1}}) ? cnt_q : cnt_q + 1'b1;
		hcrc_n = (cnt_q < CW'(cfd_pkg::CRC_COVER)) ?
			cfd_pkg::crc32c_byte(hcrc_q, data_b) : hcrc_q;
		pcrc_n = hdr_wr ? pcrc_q : cfd_pkg::crc32c_byte(pcrc_q, data_b);
		// merge the current byte into the header image
		for (int i = 0; i < cfd_pkg::HEADER_LEN; i++) begin
			hdr_v[i] = (hdr_wr && hdr_idx == IW'(i)) ? data_b : hdr_q[i];
		end
	end

	always_comb begin
		view.count             = cnt_n;
		view.magic             = {hdr_v[3], hdr_v[2], hdr_v[1], hdr_v[0]};
		view.version           = {hdr_v[5], hdr_v[4]};
		view.message_type      = {hdr_v[7], hdr_v[6]};
		view.payload_length    = {hdr_v[11], hdr_v[10], hdr_v[9], hdr_v[8]};
		view.request_tag       = {hdr_v[19], hdr_v[18], hdr_v[17], hdr_v[16],
			hdr_v[15], hdr_v[14], hdr_v[13], hdr_v[12]};
		view.payload_crc_field = {hdr_v[23], hdr_v[22], hdr_v[21], hdr_v[20]};
		view.header_crc_field  = {hdr_v[27], hdr_v[26], hdr_v[25], hdr_v[24]};
		view.header_crc_calc   = hcrc_n ^ cfd_pkg::CRC_INIT;
		view.payload_crc_calc  = pcrc_n ^ cfd_pkg::CRC_INIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			hcrc_q <= cfd_pkg::CRC_INIT;
			pcrc_q <= cfd_pkg::CRC_INIT;
		end else if (step) begin
			if (last) begin
				cnt_q  <= '0;
				hcrc_q <= cfd_pkg::CRC_INIT;
				pcrc_q <= cfd_pkg::CRC_INIT;
			end else begin
				cnt_q  <= cnt_n;
				hcrc_q <= hcrc_n;
				pcrc_q <= pcrc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && hdr_wr) begin
			hdr_q[hdr_idx] <= data_b;
		end
	end

endmodule

// File: rtl/cfd_verdict.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_verdict
// Ordered frame checks; the first failing check sets the status.
// ----------------------------------------------------------------------------
module cfd_verdict (
	input  cfd_pkg::cfd_view_t   view,
	input  cfd_pkg::cfd_cfg_t    regs,
	output cfd_pkg::cfd_result_t result
);

	localparam int CW = cfd_pkg::COUNT_W;
	localparam int TB = cfd_pkg::TYPE_BITS;

	logic          is_short;
	logic          type_known;
	logic [CW-1:0] expect_len;

	assign is_short   = view.count < CW'(cfd_pkg::HEADER_LEN);
	assign type_known = (view.message_type[15:TB] == '0) &&
		regs.known_type_mask[view.message_type[TB-1:0]];
	assign expect_len = CW'(view.payload_length) + CW'(cfd_pkg::HEADER_LEN);

	always_comb begin
		result.message_type   = view.message_type;
		result.request_tag    = view.request_tag;
		result.payload_length = view.payload_length;
		if (is_short) begin
			result.status         = cfd_pkg::ST_SHORT;
			result.message_type   = '0;
			result.request_tag    = '0;
			result.payload_length = '0;
		end else if (view.magic != regs.frame_magic) begin
			result.status = cfd_pkg::ST_MAGIC;
		end else if (view.header_crc_field != view.header_crc_calc) begin
			result.status = cfd_pkg::ST_HEADER_CRC;
		end else if (view.version != regs.accepted_version) begin
			result.status = cfd_pkg::ST_VERSION;
		end else if (!type_known) begin
			result.status = cfd_pkg::ST_TYPE;
		end else if (view.payload_length > regs.payload_limit) begin
			result.status = cfd_pkg::ST_TOO_BIG;
		end else if (view.count != expect_len) begin
			result.status = cfd_pkg::ST_LENGTH;
		end else if (view.payload_crc_field != view.payload_crc_calc) begin
			result.status = cfd_pkg::ST_PAYLOAD_CRC;
		end else begin
			result.status = cfd_pkg::ST_OK;
		end
	end

endmodule

// File: rtl/checked_frame_deframer.sv
// ----------------------------------------------------------------------------
// checked_frame_deframer
// The last byte is registered at the input, then its verdict in result_q.
// Throughput: one byte per cycle (byte-wide CRC-32C); a last byte may stall.
// Reset: count, CRCs and config restart; the header store is left as is.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "checked_frame_deframer_assert.svh"

module checked_frame_deframer (
	input  logic      clk,
	input  logic      arst_n,
	cfd_in_if.sink    item_in,
	cfd_out_if.source result_out,
	cfd_cfg_if.sink   cfg
);

	cfd_pkg::cfd_cfg_t    regs;
	cfd_pkg::cfd_view_t   view;
	cfd_pkg::cfd_result_t verdict;
	cfd_pkg::cfd_result_t result_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic       adv;
	logic       out_take;
	logic       out_short;
	logic       short_clear;

	// a non-final byte never waits on the output side
	assign adv           = valid_s1 && (!last_s1 || !out_valid_q || result_out.ready);
	assign item_in.ready = !valid_s1 || adv;

	cfd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cfd_frame_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.data_b (data_s1),
		.last   (last_s1),
		.view   (view)
	);

	cfd_verdict u_verdict (
		.view   (view),
		.regs   (regs),
		.result (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			data_s1 <= item_in.data_byte;
			last_s1 <= item_in.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			result_q <= verdict;
		end
	end

	assign result_out.valid          = out_valid_q;
	assign result_out.status         = result_q.status;
	assign result_out.message_type   = result_q.message_type;
	assign result_out.request_tag    = result_q.request_tag;
	assign result_out.payload_length = result_q.payload_length;

	assign out_take    = out_valid_q && result_out.ready;
	assign out_short   = out_valid_q && result_q.status == cfd_pkg::ST_SHORT;
	assign short_clear = result_q.request_tag == '0 && result_q.message_type == '0 &&
		result_q.payload_length == '0;

	`CFD_ASSERT_NOW(a_in_ready_when_empty, !valid_s1, item_in.ready)
	`CFD_ASSERT_NEXT(a_out_drains, out_take && !(adv && last_s1), !out_valid_q)
	`CFD_ASSERT_NOW(a_short_fields_zero, out_short, short_clear)
	`CFD_ASSERT_NOW(a_status_range, out_valid_q, result_q.status <= cfd_pkg::ST_PAYLOAD_CRC)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the checked frame deframer. Frames are built with
// valid and corrupted headers, CRCs and lengths, streamed one byte per item,
// and every verdict is compared with a bit-accurate frame tracker.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_BYTES  = 460;
	localparam int MAX_REPORTED = 100;
	localparam int CW           = cfd_pkg::COUNT_W;

	typedef struct {
		cfd_pkg::cfd_status_t status;
		logic [15:0]          message_type;
		logic [63:0]          request_tag;
		logic [31:0]          payload_length;
	} verdict_t;

	logic clk;
	logic arst_n;

	cfd_in_if  in_ch ();
	cfd_out_if out_ch ();
	cfd_cfg_if cfg_ch ();

	checked_frame_deframer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (in_ch),
		.result_out (out_ch),
		.cfg        (cfg_ch)
	);

	// register shadow
	logic [31:0] cfg_magic;
	logic [15:0] cfg_version;
	logic [31:0] cfg_limit;
	logic [63:0] cfg_mask;

	// frame tracker state
	logic [CW-1:0] rx_count;
	logic [7:0]    rx_header [cfd_pkg::HEADER_LEN];
	logic [31:0]   rx_header_crc;
	logic [31:0]   rx_payload_crc;

	verdict_t    expected_verdicts [$];
	verdict_t    verdict_seen;
	logic [7:0]  frame_q [$];
	int unsigned mismatches;
	int unsigned verdicts_checked;
	int unsigned sent_bytes;
	int unsigned stall_cycles;
	int          src_idle_pct;
	int          snk_idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] r;
		logic        fb;
		r = crc;
		for (int i = 0; i < 8; i++) begin
			fb = r[0] ^ b[i];
			r = {1'b0, r[31:1]} ^ (fb ? cfd_pkg::CRC_POLY : 32'd0);
		end
		return r;
	endfunction

	function automatic void restart_frame();
		rx_count = '0;
		rx_header_crc = cfd_pkg::CRC_INIT;
		rx_payload_crc = cfd_pkg::CRC_INIT;
	endfunction

	function automatic void apply_reg(input cfd_pkg::cfd_cfg_idx_t idx,
		input logic [63:0] value);
		case (idx)
			cfd_pkg::CFG_FRAME_MAGIC: cfg_magic = value[31:0];
			cfd_pkg::CFG_ACCEPTED_VERSION: cfg_version = value[15:0];
			cfd_pkg::CFG_PAYLOAD_LIMIT: cfg_limit = value[31:0];
			cfd_pkg::CFG_KNOWN_TYPE_MASK: cfg_mask = value;
			default: ;
		endcase
	endfunction

	// Advance the tracker by one accepted byte; queue a verdict on the last byte.
	function automatic void track_byte(input logic [7:0] b, input logic last);
		verdict_t    v;
		logic [31:0] magic;
		logic [15:0] version;
		logic [31:0] payload_crc_field;
		logic [31:0] header_crc_field;
		if (rx_count < cfd_pkg::HEADER_LEN)
			rx_header[rx_count[4:0]] = b;
		if (rx_count < cfd_pkg::CRC_COVER)
			rx_header_crc = crc_next(rx_header_crc, b);
		if (rx_count >= cfd_pkg::HEADER_LEN)
			rx_payload_crc = crc_next(rx_payload_crc, b);
		if (rx_count != '1)
			rx_count = rx_count + 1'b1;
		if (!last)
			return;
		v.status = cfd_pkg::ST_OK;
		v.message_type = '0;
		v.request_tag = '0;
		v.payload_length = '0;
		if (rx_count < cfd_pkg::HEADER_LEN) begin
			v.status = cfd_pkg::ST_SHORT;
		end else begin
			magic = {rx_header[3], rx_header[2], rx_header[1], rx_header[0]};
			version = {rx_header[5], rx_header[4]};
			v.message_type = {rx_header[7], rx_header[6]};
			v.payload_length = {rx_header[11], rx_header[10], rx_header[9], rx_header[8]};
			v.request_tag = {rx_header[19], rx_header[18], rx_header[17], rx_header[16],
				rx_header[15], rx_header[14], rx_header[13], rx_header[12]};
			payload_crc_field = {rx_header[23], rx_header[22], rx_header[21], rx_header[20]};
			header_crc_field = {rx_header[27], rx_header[26], rx_header[25], rx_header[24]};
			if (magic != cfg_magic)
				v.status = cfd_pkg::ST_MAGIC;
			else if (header_crc_field != (rx_header_crc ^ cfd_pkg::CRC_INIT))
				v.status = cfd_pkg::ST_HEADER_CRC;
			else if (version != cfg_version)
				v.status = cfd_pkg::ST_VERSION;
			else if (v.message_type >= 16'd64 || !cfg_mask[v.message_type[5:0]])
				v.status = cfd_pkg::ST_TYPE;
			else if (v.payload_length > cfg_limit)
				v.status = cfd_pkg::ST_TOO_BIG;
			else if (rx_count != CW'(cfd_pkg::HEADER_LEN) + {1'b0, v.payload_length})
				v.status = cfd_pkg::ST_LENGTH;
			else if (payload_crc_field != (rx_payload_crc ^ cfd_pkg::CRC_INIT))
				v.status = cfd_pkg::ST_PAYLOAD_CRC;
		end
		expected_verdicts.push_back(v);
		restart_frame();
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < MAX_REPORTED)
			$display("%0t verdict %0d: %s got %h want %h", $time, verdicts_checked, what, got,
				want);
		mismatches++;
	endtask

	// Receiver: stall at random at the set rate.
	always @(negedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				report_mismatch("verdict with none pending", 64'(out_ch.status), 64'd0);
			end else begin
				verdict_seen = expected_verdicts.pop_front();
				if (out_ch.status !== verdict_seen.status)
					report_mismatch("status", 64'(out_ch.status), 64'(verdict_seen.status));
				if (out_ch.message_type !== verdict_seen.message_type)
					report_mismatch("message_type", 64'(out_ch.message_type),
						64'(verdict_seen.message_type));
				if (out_ch.request_tag !== verdict_seen.request_tag)
					report_mismatch("request_tag", out_ch.request_tag,
						verdict_seen.request_tag);
				if (out_ch.payload_length !== verdict_seen.payload_length)
					report_mismatch("payload_length", 64'(out_ch.payload_length),
						64'(verdict_seen.payload_length));
			end
			verdicts_checked++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// All driving tasks are entered and left on a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.frame_end <= last;
		do @(posedge clk); while (!in_ch.ready);
		track_byte(b, last);
		sent_bytes++;
		@(negedge clk);
	endtask

	task automatic send_frame(input int n);
		for (int i = 0; i < n; i++)
			send_byte(frame_q[i], i == n - 1);
	endtask

	task automatic wait_for_verdicts();
		in_ch.valid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input cfd_pkg::cfd_cfg_idx_t idx, input logic [63:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, value);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Fill frame_q with a header and a random payload.
	task automatic build_frame(input logic [31:0] magic, input logic [15:0] version,
		input logic [15:0] mtype, input logic [63:0] tag, input int pay_len,
		input logic [31:0] plen_field, input logic bad_hcrc, input logic bad_pcrc);
		logic [7:0]  hdr [cfd_pkg::HEADER_LEN];
		logic [7:0]  payload [$];
		logic [7:0]  b;
		logic [31:0] pcrc;
		logic [31:0] hcrc;
		pcrc = cfd_pkg::CRC_INIT;
		for (int i = 0; i < pay_len; i++) begin
			b = 8'($urandom);
			payload.push_back(b);
			pcrc = crc_next(pcrc, b);
		end
		pcrc ^= cfd_pkg::CRC_INIT;
		if (bad_pcrc)
			pcrc ^= 32'd1 << $urandom_range(31);
		for (int i = 0; i < 4; i++) begin
			hdr[i] = magic[8*i +: 8];
			hdr[8 + i] = plen_field[8*i +: 8];
			hdr[20 + i] = pcrc[8*i +: 8];
		end
		for (int i = 0; i < 2; i++) begin
			hdr[4 + i] = version[8*i +: 8];
			hdr[6 + i] = mtype[8*i +: 8];
		end
		for (int i = 0; i < 8; i++)
			hdr[12 + i] = tag[8*i +: 8];
		hcrc = cfd_pkg::CRC_INIT;
		for (int i = 0; i < cfd_pkg::CRC_COVER; i++)
			hcrc = crc_next(hcrc, hdr[i]);
		hcrc ^= cfd_pkg::CRC_INIT;
		if (bad_hcrc)
			hcrc ^= 32'd1 << $urandom_range(31);
		for (int i = 0; i < 4; i++)
			hdr[24 + i] = hcrc[8*i +: 8];
		frame_q.delete();
		for (int i = 0; i < cfd_pkg::HEADER_LEN; i++)
			frame_q.push_back(hdr[i]);
		foreach (payload[i])
			frame_q.push_back(payload[i]);
	endtask

	function automatic logic [15:0] pick_type();
		int          r;
		logic [15:0] t;
		r = $urandom_range(99);
		if (r < 80 && cfg_mask != '0) begin
			do t = 16'($urandom_range(63)); while (!cfg_mask[t[5:0]]);
		end else if (r < 90) begin
			t = 16'($urandom_range(127));
		end else begin
			t = 16'($urandom);
		end
		return t;
	endfunction

	task automatic send_random_frame();
		int          r;
		int          fault;
		int          pay_len;
		logic [31:0] magic;
		logic [15:0] version;
		logic [31:0] plen_field;
		// hold off now and then until the block has answered everything
		if ($urandom_range(99) < 4)
			wait_for_verdicts();
		r = $urandom_range(99);
		if (r < 8) begin
			frame_q.delete();
			repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
			send_frame(frame_q.size());
			return;
		end
		r = $urandom_range(99);
		if (r < 90)
			pay_len = $urandom_range(0, 20);
		else if (r < 98)
			pay_len = $urandom_range(21, 120);
		else
			pay_len = $urandom_range(121, 400);
		fault = $urandom_range(0, 13);
		magic = cfg_magic;
		version = cfg_version;
		plen_field = pay_len;
		if (fault == 0)
			magic ^= 32'd1 << $urandom_range(31);
		if (fault == 2)
			version ^= 16'd1 << $urandom_range(15);
		if (fault == 3) begin
			case ($urandom_range(2))
				0: plen_field = $urandom;
				1: plen_field = pay_len + $urandom_range(1, 3);
				default: plen_field = pay_len - 1;
			endcase
		end
		build_frame(magic, version, pick_type(), {$urandom, $urandom}, pay_len, plen_field,
			fault == 1, fault == 4);
		// cut the header short
		if (fault == 5)
			send_frame($urandom_range(1, cfd_pkg::HEADER_LEN - 1));
		else
			send_frame(frame_q.size());
	endtask

	task automatic test_directed_checks();
		frame_q = {8'hFF};
		send_frame(1);
		build_frame(cfg_magic, cfg_version, 16'd0, 64'd0, 0, 32'd0, 1'b0, 1'b0);
		send_frame(cfd_pkg::HEADER_LEN - 1);
		build_frame(cfg_magic, cfg_version, 16'd0, 64'd0, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd28, '1, 5, 32'd5, 1'b0, 1'b0);
		send_frame(frame_q.size());
		// types outside the reset mask
		build_frame(cfg_magic, cfg_version, 16'd29, 64'd1, 2, 32'd2, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd64, 64'd2, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'hFFFF, 64'd3, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		// bad magic wins over a bad header CRC
		build_frame(~cfg_magic, cfg_version, 16'd1, 64'd4, 1, 32'd1, 1'b1, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd1, 64'd5, 1, 32'd1, 1'b1, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version ^ 16'd1, 16'd1, 64'd6, 1, 32'd1, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd2, 64'd7, 3, 32'hFFFF_FFFF, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd2, 64'd8, 3, 32'd2, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd2, 64'd9, 2, 32'd3, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd3, 64'd10, 4, 32'd4, 1'b0, 1'b1);
		send_frame(frame_q.size());
		wait_for_verdicts();
	endtask

	task automatic test_register_extremes();
		write_reg(cfd_pkg::CFG_FRAME_MAGIC, {$urandom, 32'hFFFF_FFFF});
		write_reg(cfd_pkg::CFG_ACCEPTED_VERSION, {$urandom, 16'($urandom), 16'hFFFF});
		write_reg(cfd_pkg::CFG_PAYLOAD_LIMIT, {$urandom, 32'd0});
		write_reg(cfd_pkg::CFG_KNOWN_TYPE_MASK, '1);
		build_frame(cfg_magic, cfg_version, 16'd63, '1, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd63, 64'd1, 1, 32'd1, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(32'd0, cfg_version, 16'd0, 64'd2, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		wait_for_verdicts();
		write_reg(cfd_pkg::CFG_FRAME_MAGIC, {$urandom, $urandom});
		write_reg(cfd_pkg::CFG_ACCEPTED_VERSION, {$urandom, $urandom});
		write_reg(cfd_pkg::CFG_PAYLOAD_LIMIT, {$urandom, 32'd10});
		write_reg(cfd_pkg::CFG_KNOWN_TYPE_MASK, 64'h8000_0000_0000_0001);
		build_frame(cfg_magic, cfg_version, 16'd63, 64'd3, 10, 32'd10, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd0, 64'd4, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd1, 64'd5, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		build_frame(cfg_magic, cfg_version, 16'd0, 64'd6, 11, 32'd11, 1'b0, 1'b0);
		send_frame(frame_q.size());
		wait_for_verdicts();
		write_reg(cfd_pkg::CFG_KNOWN_TYPE_MASK, 64'd0);
		build_frame(cfg_magic, cfg_version, 16'd0, 64'd7, 0, 32'd0, 1'b0, 1'b0);
		send_frame(frame_q.size());
		wait_for_verdicts();
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct,
		input logic [31:0] magic, input logic [15:0] version, input logic [31:0] limit,
		input logic [63:0] mask);
		int unsigned start;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		write_reg(cfd_pkg::CFG_FRAME_MAGIC, {$urandom, magic});
		write_reg(cfd_pkg::CFG_ACCEPTED_VERSION, {$urandom, 16'($urandom), version});
		write_reg(cfd_pkg::CFG_PAYLOAD_LIMIT, {$urandom, limit});
		write_reg(cfd_pkg::CFG_KNOWN_TYPE_MASK, mask);
		start = sent_bytes;
		while (sent_bytes - start < PHASE_BYTES)
			send_random_frame();
		wait_for_verdicts();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.frame_end = 1'b0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		sent_bytes = 0;
		src_idle_pct = 20;
		snk_idle_pct = 52;
		cfg_magic = cfd_pkg::MAGIC_RST;
		cfg_version = cfd_pkg::VERSION_RST;
		cfg_limit = cfd_pkg::LIMIT_RST;
		cfg_mask = cfd_pkg::MASK_RST;
		foreach (rx_header[i])
			rx_header[i] = '0;
		restart_frame();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_checks();
		test_register_extremes();
		test_random_traffic(20, 52, $urandom, 16'($urandom), $urandom_range(4, 30),
			{$urandom, $urandom});
		test_random_traffic(52, 20, $urandom, 16'($urandom), 32'hFFFF_FFFF, '1);
		test_random_traffic(0, 0, 32'd0, 16'($urandom), $urandom_range(0, 64),
			{$urandom, $urandom} | 64'h1);

		repeat (5) @(posedge clk);
		if (expected_verdicts.size() != 0)
			report_mismatch("verdicts still pending", 64'(expected_verdicts.size()), 64'd0);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
